// ===== rtl/q2r_pkg.sv =====
// Shared types and constants for the quaternion to rotation matrix pipeline.
// No dependencies; every other file imports this package.
package q2r_pkg;

  localparam int OUT_W     = 16;  // Q2.14 matrix entry
  localparam int N_ENT     = 9;   // entries of the 3x3 matrix
  localparam int N_PROD    = 10;  // pairwise products
  localparam int DIV_STEPS = 16;  // one integer bit plus 15 fraction bits
  localparam int QUO_W     = 16;
  localparam int CFG_W     = 32;
  localparam int THR_FRAC  = 30;  // fraction bits of the threshold register

  localparam logic [CFG_W-1:0] THR_RESET = 32'd1074;
  localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [QUO_W-1:0] SAT_Q14 = 16'd16384;

  // Product slots
  localparam int P_WW = 0;
  localparam int P_XX = 1;
  localparam int P_YY = 2;
  localparam int P_ZZ = 3;
  localparam int P_XY = 4;
  localparam int P_WZ = 5;
  localparam int P_WY = 6;
  localparam int P_XZ = 7;
  localparam int P_YZ = 8;
  localparam int P_WX = 9;

  typedef logic signed [OUT_W-1:0] entry_t;

  typedef struct packed {
    logic             valid;
    logic             degenerate;
    logic [N_ENT-1:0] neg;
  } q2r_ctl_t;

endpackage

// ===== rtl/q2r_if.sv =====
// Handshake channels: quaternion input and rotation matrix output.
// Depends on q2r_pkg for the entry type.
interface q2r_quat_if #(parameter int COMPONENT_BITS = 16) ();
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] quat_w;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2r_mat_if import q2r_pkg::*; ();
  logic   valid;
  logic   ready;
  entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic   degenerate;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                 input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
               output ready);
endinterface

// ===== rtl/q2r_front.sv =====
// Front end: products, numerator and norm sums, sign/magnitude and threshold compare.
// Three register stages; depends on q2r_pkg.
module q2r_front import q2r_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  localparam int NW = 2 * COMPONENT_BITS + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [2:0]                       en,
  input  logic                             valid_in,
  input  logic signed [COMPONENT_BITS-1:0] w,
  input  logic signed [COMPONENT_BITS-1:0] x,
  input  logic signed [COMPONENT_BITS-1:0] y,
  input  logic signed [COMPONENT_BITS-1:0] z,
  input  logic [CFG_W-1:0]                 thr,
  output logic [1:0]                       early_valid,
  output q2r_ctl_t                         ctl,
  output logic [NW-1:0]                    norm,
  output logic [N_ENT-1:0][NW-1:0]         mag
);

  localparam int PW    = 2 * COMPONENT_BITS;
  localparam int SW    = PW + 2;
  localparam int FRAC2 = 2 * (COMPONENT_BITS - 1);
  localparam int SH_L  = (FRAC2 < THR_FRAC) ? THR_FRAC - FRAC2 : 0;
  localparam int SH_R  = (FRAC2 >= THR_FRAC) ? FRAC2 - THR_FRAC : 0;
  localparam int CW    = (NW + SH_L > CFG_W + SH_R) ? NW + SH_L : CFG_W + SH_R;

  logic                 v0, v1;
  logic signed [PW-1:0] prod [N_PROD];
  logic signed [SW-1:0] num  [N_ENT];
  logic signed [SW-1:0] num_next [N_ENT];
  logic [NW-1:0]        norm1;
  logic signed [SW-1:0] s [N_PROD];
  logic [CW-1:0]        lhs, rhs;
  logic [N_ENT-1:0]     neg_next;
  logic [N_ENT-1:0][NW-1:0] mag_next;
  logic signed [SW-1:0] flip;

  assign early_valid = {v1, v0};

  // Stage 0: ten products, one multiplier each
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en[0]) begin
      v0 <= valid_in;
    end
    if (en[0]) begin
      prod[P_WW] <= w * w;
      prod[P_XX] <= x * x;
      prod[P_YY] <= y * y;
      prod[P_ZZ] <= z * z;
      prod[P_XY] <= x * y;
      prod[P_WZ] <= w * z;
      prod[P_WY] <= w * y;
      prod[P_XZ] <= x * z;
      prod[P_YZ] <= y * z;
      prod[P_WX] <= w * x;
    end
  end

  // Stage 1: signed numerators and the squared norm
  always_comb begin
    for (int k = 0; k < N_PROD; k++) begin
      s[k] = SW'(prod[k]);
    end
    num_next[0] = s[P_WW] + s[P_XX] - s[P_YY] - s[P_ZZ];
    num_next[1] = (s[P_XY] - s[P_WZ]) <<< 1;
    num_next[2] = (s[P_WY] + s[P_XZ]) <<< 1;
    num_next[3] = (s[P_WZ] + s[P_XY]) <<< 1;
    num_next[4] = s[P_WW] - s[P_XX] + s[P_YY] - s[P_ZZ];
    num_next[5] = (s[P_YZ] - s[P_WX]) <<< 1;
    num_next[6] = (s[P_XZ] - s[P_WY]) <<< 1;
    num_next[7] = (s[P_WX] + s[P_YZ]) <<< 1;
    num_next[8] = s[P_WW] - s[P_XX] - s[P_YY] + s[P_ZZ];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en[1]) begin
      v1 <= v0;
    end
    if (en[1]) begin
      num   <= num_next;
      norm1 <= NW'(s[P_WW] + s[P_XX] + s[P_YY] + s[P_ZZ]);
    end
  end

  // Stage 2: magnitudes and the threshold compare at common fraction bits
  always_comb begin
    flip = '0;
    for (int k = 0; k < N_ENT; k++) begin
      flip        = -num[k];
      neg_next[k] = num[k][SW-1];
      mag_next[k] = num[k][SW-1] ? NW'(flip) : NW'(num[k]);
    end
    lhs = CW'(norm1) << SH_L;
    rhs = CW'(thr) << SH_R;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en[2]) begin
      ctl.valid <= v1;
    end
    if (en[2]) begin
      ctl.degenerate <= !(lhs > rhs);
      ctl.neg        <= neg_next;
      norm           <= norm1;
      mag            <= mag_next;
    end
  end

endmodule

// ===== rtl/q2r_div_step.sv =====
// One restoring division step for all nine entries: one quotient bit per stage.
// Depends on q2r_pkg.
module q2r_div_step import q2r_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int STEP = 0,
  localparam int NW = 2 * COMPONENT_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  q2r_ctl_t                    ctl_in,
  input  logic [NW-1:0]               norm_in,
  input  logic [N_ENT-1:0][NW-1:0]    rem_in,
  input  logic [N_ENT-1:0][QUO_W-1:0] quo_in,
  output q2r_ctl_t                    ctl,
  output logic [NW-1:0]               norm,
  output logic [N_ENT-1:0][NW-1:0]    rem,
  output logic [N_ENT-1:0][QUO_W-1:0] quo
);

  localparam int RW = NW + 1;

  logic [RW-1:0]             trial;
  logic [RW-1:0]             diff;
  logic [N_ENT-1:0]          ge;
  logic [N_ENT-1:0][NW-1:0]  rem_next;

  // The first step yields the integer bit, the rest shift then subtract
  always_comb begin
    trial = '0;
    diff  = '0;
    for (int k = 0; k < N_ENT; k++) begin
      trial       = (STEP == 0) ? {1'b0, rem_in[k]} : {rem_in[k], 1'b0};
      diff        = trial - {1'b0, norm_in};
      ge[k]       = trial >= {1'b0, norm_in};
      rem_next[k] = ge[k] ? diff[NW-1:0] : trial[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl.degenerate <= ctl_in.degenerate;
      ctl.neg        <= ctl_in.neg;
      norm           <= norm_in;
      rem            <= rem_next;
      for (int k = 0; k < N_ENT; k++) begin
        quo[k] <= {quo_in[k][QUO_W-2:0], ge[k]};
      end
    end
  end

endmodule

// ===== rtl/q2r_back.sv =====
// Output stage: round the quotients to Q2.14, saturate at one, apply signs, substitute identity.
// Depends on q2r_pkg.
module q2r_back import q2r_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  q2r_ctl_t                    ctl_in,
  input  logic [N_ENT-1:0][QUO_W-1:0] quo_in,
  output logic                        valid,
  output logic                        degenerate,
  output entry_t [N_ENT-1:0]          ent
);

  logic [QUO_W:0]            sum;
  logic [QUO_W-1:0]          rnd;
  entry_t [N_ENT-1:0]        ent_next;

  always_comb begin
    sum = '0;
    rnd = '0;
    for (int k = 0; k < N_ENT; k++) begin
      sum = {1'b0, quo_in[k]} + 17'd1;
      rnd = sum[QUO_W:1];
      if (rnd > SAT_Q14) begin
        rnd = SAT_Q14;
      end
      ent_next[k] = ctl_in.neg[k] ? -entry_t'(rnd) : entry_t'(rnd);
      if (ctl_in.degenerate) begin
        ent_next[k] = (k == 0 || k == 4 || k == 8) ? ONE_Q14 : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
    if (en) begin
      degenerate <= ctl_in.degenerate;
      ent        <= ent_next;
    end
  end

endmodule

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, top level. Uses q2r_pkg, the q2r_if channels,
// q2r_front, q2r_div_step and q2r_back.
//
// Takes one quaternion per clock and returns the normalized rotation matrix in Q2.14,
// sustaining one transaction per cycle while the output is ready. There are twenty
// register stages: three front stages (products, sums, sign and threshold compare),
// the nine-lane restoring divider with one quotient bit per stage over sixteen
// stages, and one rounding stage, whose register offers the matrix. Each stage holds
// a valid bit and advances when the stage after it is empty or advancing. Bubbles
// collapse, and input stays ready while a finished matrix waits at the output as long
// as some stage is still empty; once all twenty are full, input waits on the output.
// When the squared norm is at or below the threshold (Q2.30) the identity is given
// with degenerate set. Write the threshold only while the pipeline is empty.
module quaternion_to_rotation_matrix import q2r_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  q2r_quat_if.sink         quat,
  q2r_mat_if.source        mat
);

  localparam int NW = 2 * COMPONENT_BITS + 1;
  localparam int NS = 3 + DIV_STEPS + 1;

  logic [CFG_W-1:0] thr;
  logic [NS-1:0]    v;
  logic [NS-1:0]    en;

  q2r_ctl_t                    ctl_d  [DIV_STEPS+1];
  logic [NW-1:0]               norm_d [DIV_STEPS+1];
  logic [N_ENT-1:0][NW-1:0]    rem_d  [DIV_STEPS+1];
  logic [N_ENT-1:0][QUO_W-1:0] quo_d  [DIV_STEPS+1];
  logic [1:0]                  early_valid;
  logic                        out_degenerate;
  entry_t [N_ENT-1:0]          ent;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // Advance a stage when the next one is free or moving
  assign en[NS-1] = !v[NS-1] || mat.ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end
  assign quat.ready = en[0];

  q2r_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en[2:0]),
    .valid_in    (quat.valid),
    .w           (quat.quat_w),
    .x           (quat.quat_x),
    .y           (quat.quat_y),
    .z           (quat.quat_z),
    .thr         (thr),
    .early_valid (early_valid),
    .ctl         (ctl_d[0]),
    .norm        (norm_d[0]),
    .mag         (rem_d[0])
  );
  assign v[1:0] = early_valid;
  assign v[2]   = ctl_d[0].valid;
  assign quo_d[0] = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    q2r_div_step #(.COMPONENT_BITS(COMPONENT_BITS), .STEP(k)) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en[3+k]),
      .ctl_in  (ctl_d[k]),
      .norm_in (norm_d[k]),
      .rem_in  (rem_d[k]),
      .quo_in  (quo_d[k]),
      .ctl     (ctl_d[k+1]),
      .norm    (norm_d[k+1]),
      .rem     (rem_d[k+1]),
      .quo     (quo_d[k+1])
    );
    assign v[3+k] = ctl_d[k+1].valid;
  end

  q2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en[NS-1]),
    .ctl_in     (ctl_d[DIV_STEPS]),
    .quo_in     (quo_d[DIV_STEPS]),
    .valid      (v[NS-1]),
    .degenerate (out_degenerate),
    .ent        (ent)
  );

  assign mat.valid      = v[NS-1];
  assign mat.degenerate = out_degenerate;
  assign mat.m00 = ent[0];
  assign mat.m01 = ent[1];
  assign mat.m02 = ent[2];
  assign mat.m10 = ent[3];
  assign mat.m11 = ent[4];
  assign mat.m12 = ent[5];
  assign mat.m20 = ent[6];
  assign mat.m21 = ent[7];
  assign mat.m22 = ent[8];

  // An accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.ready |=> v[0])
    else $error("accepted quaternion did not enter stage 0");

  // An empty first stage never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> quat.ready)
    else $error("input stalled with stage 0 empty");

  // Degenerate results carry the identity
  a_identity: assert property (@(posedge clk) disable iff (rst)
    mat.valid && mat.degenerate |-> mat.m00 == ONE_Q14 && mat.m11 == ONE_Q14 &&
      mat.m22 == ONE_Q14 && mat.m01 == '0 && mat.m12 == '0 && mat.m20 == '0)
    else $error("degenerate result is not the identity");

  // The first two diagonal entries stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    mat.valid |-> mat.m00 <= ONE_Q14 && mat.m00 >= -ONE_Q14 &&
      mat.m11 <= ONE_Q14 && mat.m11 >= -ONE_Q14)
    else $error("matrix entry out of range");

endmodule
